// File: design/string_to_integer_parser_defines.svh
// Assertion macros shared by the string-to-integer parser RTL.
// Depends on nothing; included by modules that carry assertions.
`ifndef STRING_TO_INTEGER_PARSER_DEFINES_SVH
`define STRING_TO_INTEGER_PARSER_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define STIP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define STIP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: design/stip_pkg.sv
// Package for the string-to-integer parser: widths, parse phase codes,
// status codes, character constants and the digit decoder. No dependencies.
package stip_pkg;

   // Default parameter values and fixed port widths.
   localparam int VALUE_BITS_DEF  = 64;
   localparam int OFFSET_BITS_DEF = 16;
   localparam int CHAR_W          = 8;
   localparam int RADIX_W         = 6;
   localparam int VALUE_W         = 64;
   localparam int END_W           = 16;
   localparam int STATUS_W        = 2;
   localparam int RSP_FIELDS_W    = VALUE_W + END_W + STATUS_W;
   localparam int RSP_TDATA_W     = ((RSP_FIELDS_W + 7) / 8) * 8;
   localparam int PHASE_W         = 3;

   // Parse phase codes.
   localparam logic [PHASE_W-1:0] PH_SPACE   = 3'd0;
   localparam logic [PHASE_W-1:0] PH_SIGNED  = 3'd1;
   localparam logic [PHASE_W-1:0] PH_ZERO    = 3'd2;
   localparam logic [PHASE_W-1:0] PH_XSEEN   = 3'd3;
   localparam logic [PHASE_W-1:0] PH_DIGITS  = 3'd4;
   localparam logic [PHASE_W-1:0] PH_DONE    = 3'd5;
   localparam logic [PHASE_W-1:0] PH_INVALID = 3'd6;

   // Result status codes.
   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_BAD_BASE  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NO_DIGITS = 2'd2;
   localparam logic [STATUS_W-1:0] ST_RANGE     = 2'd3;

   // Bases.
   localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
   localparam logic [RADIX_W-1:0] BASE_AUTO   = 6'd0;
   localparam logic [RADIX_W-1:0] BASE_ONE    = 6'd1;
   localparam logic [RADIX_W-1:0] BASE_MIN    = 6'd2;
   localparam logic [RADIX_W-1:0] BASE_OCT    = 6'd8;
   localparam logic [RADIX_W-1:0] BASE_DEC    = 6'd10;
   localparam logic [RADIX_W-1:0] BASE_HEX    = 6'd16;
   localparam logic [RADIX_W-1:0] BASE_MAX    = 6'd36;

   // Characters.
   localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
   localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
   localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
   localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
   localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
   localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
   localparam logic [CHAR_W-1:0] CH_7     = 8'h37;
   localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
   localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
   localparam logic [CHAR_W-1:0] CH_UX    = 8'h58;
   localparam logic [CHAR_W-1:0] CH_UZ    = 8'h5A;
   localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
   localparam logic [CHAR_W-1:0] CH_LX    = 8'h78;
   localparam logic [CHAR_W-1:0] CH_LZ    = 8'h7A;

   // Decoded digit: value 0..35 when valid.
   typedef struct packed {
      logic               valid;
      logic [RADIX_W-1:0] value;
   } digit_type;

   function automatic digit_type digit_decode(input logic [CHAR_W-1:0] c);
      digit_type d;
      d.valid = 1'b1;
      d.value = '0;
      if (c >= CH_0 && c <= CH_9) begin
         d.value = RADIX_W'(c - CH_0);
      end else if (c >= CH_LA && c <= CH_LZ) begin
         d.value = RADIX_W'(c - CH_LA) + BASE_DEC;
      end else if (c >= CH_UA && c <= CH_UZ) begin
         d.value = RADIX_W'(c - CH_UA) + BASE_DEC;
      end else begin
         d.valid = 1'b0;
      end
      return d;
   endfunction

endpackage

// File: design/string_to_integer_parser.sv
// Streaming strtol-style string-to-integer parser, top level.
// Depends on stip_pkg and string_to_integer_parser_defines.svh.
//
//   Channel  Direction  Payload (low bit first)                   Handshake
//   req      in         tdata: character[7:0]                     tvalid/tready
//   rsp      out        tdata: value[63:0], end_offset[79:64],    tvalid/tready
//                              status[81:80], zero pad[87:82]
//   csr      in         csr_wr_data: radix[5:0]                   csr_wr_en
//
// One character per cycle. An accepted character sits in the input register,
// then one multiply-by-base, add and limit compare update the parse state;
// the zero terminator loads the result register, which drives rsp_tvalid.
// Only a terminator can stall, when the result register is still full.
// Synchronous active-high reset; radix resets to 10.
module string_to_integer_parser #(
   parameter int VALUE_BITS  = stip_pkg::VALUE_BITS_DEF,
   parameter int OFFSET_BITS = stip_pkg::OFFSET_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   // character[7:0]
   input  logic [stip_pkg::CHAR_W-1:0]      req_tdata,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // value[63:0], end_offset[79:64], status[81:80], zero pad above
   output logic [stip_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic                             csr_wr_en,
   input  logic [stip_pkg::RADIX_W-1:0]     csr_wr_data
);

   import stip_pkg::*;
   `include "string_to_integer_parser_defines.svh"

   localparam int PROD_W = VALUE_BITS + RADIX_W + 1;
   localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = '1;

   // Configuration and input register.
   logic [RADIX_W-1:0]     radix_ff;
   logic                   in_valid_ff;
   logic [CHAR_W-1:0]      in_char_ff;

   // Parse state.
   logic [PHASE_W-1:0]     phase_ff, phase_in;
   logic [VALUE_BITS-1:0]  acc_ff, acc_in;
   logic                   neg_ff, neg_in;
   logic [RADIX_W-1:0]     base_ff, base_in;
   logic                   ovf_ff, ovf_in;
   logic                   seen_ff, seen_in;
   logic [OFFSET_BITS-1:0] pos_ff, pos_in;
   logic [OFFSET_BITS-1:0] nend_ff, nend_in;
   logic [OFFSET_BITS-1:0] pzend_ff, pzend_in;

   // Result register.
   logic                   out_valid_ff;
   logic [VALUE_W-1:0]     out_value_ff, out_value_in;
   logic [END_W-1:0]       out_end_ff, out_end_in;
   logic [STATUS_W-1:0]    out_status_ff, out_status_in;

   logic                   is_term;
   logic                   advance;
   logic                   out_load;
   logic [VALUE_BITS-1:0]  limit;
   logic [VALUE_BITS-1:0]  ovf_limit;

   // Handshake: a terminator waits only for the result register to free up.
   assign is_term    = (in_char_ff == CH_NUL);
   assign advance    = in_valid_ff && (!is_term || !out_valid_ff || rsp_tready);
   assign out_load   = advance && is_term;
   assign req_tready = !in_valid_ff || advance;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {(RSP_TDATA_W - RSP_FIELDS_W)'(0), out_status_ff, out_end_ff,
                        out_value_ff};

   // Largest magnitude for the current sign, also used by the overflow check.
   assign limit = {1'b0, {(VALUE_BITS - 1){1'b1}}} + VALUE_BITS'(neg_ff);
   assign ovf_limit = limit;

   // Per-character parse step.
   always_comb begin
      logic                   first;
      logic [PHASE_W-1:0]     ph;
      logic [RADIX_W-1:0]     base0;
      logic [OFFSET_BITS-1:0] after;
      logic                   take;
      logic [RADIX_W-1:0]     tb;
      digit_type              dg;
      logic [PROD_W-1:0]      prod;
      logic [VALUE_BITS-1:0]  mag;

      first = (phase_ff == PH_SPACE) && (pos_ff == '0);
      ph    = phase_ff;
      base0 = base_ff;
      if (first) begin
         base0 = radix_ff;
         if (radix_ff == BASE_ONE || radix_ff > BASE_MAX) begin
            ph = PH_INVALID;
         end
      end
      after = (pos_ff != OFFSET_MAX) ? pos_ff + 1'b1 : pos_ff;
      dg    = digit_decode(in_char_ff);
      take  = 1'b0;
      tb    = base0;
      prod  = '0;
      mag   = '0;

      phase_in = ph;
      acc_in   = acc_ff;
      neg_in   = neg_ff;
      base_in  = base0;
      ovf_in   = ovf_ff;
      seen_in  = seen_ff;
      pos_in   = after;
      nend_in  = nend_ff;
      pzend_in = pzend_ff;

      out_value_in  = '0;
      out_end_in    = '0;
      out_status_in = ST_OK;

      if (is_term) begin
         // Terminator: form the result and return to the reset state.
         if (ph == PH_INVALID) begin
            out_status_in = ST_BAD_BASE;
         end else if (!seen_ff) begin
            out_status_in = ST_NO_DIGITS;
         end else begin
            mag           = neg_ff ? (~acc_ff + 1'b1) : acc_ff;
            out_value_in  = VALUE_W'(signed'(mag));
            out_end_in    = END_W'(nend_ff);
            out_status_in = ovf_ff ? ST_RANGE : ST_OK;
         end
         phase_in = PH_SPACE;
         acc_in   = '0;
         neg_in   = 1'b0;
         base_in  = BASE_AUTO;
         ovf_in   = 1'b0;
         seen_in  = 1'b0;
         pos_in   = '0;
         nend_in  = '0;
         pzend_in = '0;
      end else begin
         // Phase decode picks whether this character is a digit and in which base.
         unique case (ph) inside
            PH_SPACE, PH_SIGNED: begin
               if (ph == PH_SPACE && (in_char_ff == CH_SPACE ||
                   (in_char_ff >= CH_TAB && in_char_ff <= CH_CR))) begin
                  phase_in = PH_SPACE;
               end else if (ph == PH_SPACE && in_char_ff == CH_MINUS) begin
                  neg_in   = 1'b1;
                  phase_in = PH_SIGNED;
               end else if (ph == PH_SPACE && in_char_ff == CH_PLUS) begin
                  phase_in = PH_SIGNED;
               end else if (in_char_ff == CH_0 &&
                            (base0 == BASE_AUTO || base0 == BASE_HEX)) begin
                  seen_in  = 1'b1;
                  nend_in  = after;
                  pzend_in = after;
                  phase_in = PH_ZERO;
               end else begin
                  tb   = (base0 == BASE_AUTO) ? BASE_DEC : base0;
                  take = 1'b1;
               end
            end
            PH_ZERO: begin
               if (in_char_ff == CH_LX || in_char_ff == CH_UX) begin
                  phase_in = PH_XSEEN;
               end else begin
                  if (base0 == BASE_AUTO) begin
                     tb = (in_char_ff >= CH_0 && in_char_ff <= CH_7) ? BASE_OCT : BASE_DEC;
                  end
                  take = 1'b1;
               end
            end
            PH_XSEEN: begin
               if (dg.valid && dg.value < BASE_HEX) begin
                  tb   = BASE_HEX;
                  take = 1'b1;
               end else begin
                  base_in  = (base0 == BASE_AUTO) ? BASE_DEC : base0;
                  nend_in  = pzend_ff;
                  phase_in = PH_DONE;
               end
            end
            PH_DIGITS: begin
               take = 1'b1;
            end
            default: begin
               phase_in = ph;
            end
         endcase

         // Digit accumulation with saturation at the signed limit.
         if (take) begin
            base_in = tb;
            if (!dg.valid || dg.value >= tb || tb < BASE_MIN) begin
               phase_in = PH_DONE;
            end else begin
               phase_in = PH_DIGITS;
               seen_in  = 1'b1;
               nend_in  = after;
               if (!ovf_ff) begin
                  prod = PROD_W'(acc_ff) * PROD_W'(tb) + PROD_W'(dg.value);
                  if (prod > PROD_W'(limit)) begin
                     ovf_in = 1'b1;
                     acc_in = limit;
                  end else begin
                     acc_in = VALUE_BITS'(prod);
                  end
               end
            end
         end
      end
   end

   // Control and parse state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff     <= RADIX_RESET;
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         phase_ff     <= PH_SPACE;
         acc_ff       <= '0;
         neg_ff       <= 1'b0;
         base_ff      <= BASE_AUTO;
         ovf_ff       <= 1'b0;
         seen_ff      <= 1'b0;
         pos_ff       <= '0;
         nend_ff      <= '0;
         pzend_ff     <= '0;
      end else begin
         if (csr_wr_en) begin
            radix_ff <= csr_wr_data;
         end
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (out_load) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
         if (advance) begin
            phase_ff <= phase_in;
            acc_ff   <= acc_in;
            neg_ff   <= neg_in;
            base_ff  <= base_in;
            ovf_ff   <= ovf_in;
            seen_ff  <= seen_in;
            pos_ff   <= pos_in;
            nend_ff  <= nend_in;
            pzend_ff <= pzend_in;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_char_ff <= req_tdata;
      end
      if (out_load) begin
         out_value_ff  <= out_value_in;
         out_end_ff    <= out_end_in;
         out_status_ff <= out_status_in;
      end
   end

   // A saturated accumulator holds exactly the limit for its sign.
   `STIP_ASSERT_NOW(a_ovf_at_limit, clock, reset, ovf_ff, acc_ff == ovf_limit,
      "overflow flag set but accumulator is not at the limit")

   // Error results carry zero value and zero offset.
   `STIP_ASSERT_NOW(a_err_zero, clock, reset,
      out_valid_ff && (out_status_ff == ST_BAD_BASE || out_status_ff == ST_NO_DIGITS),
      out_value_ff == '0 && out_end_ff == '0,
      "error result with nonzero value or offset")

   // Once the number has ended, only a terminator leaves the done phase.
   `STIP_ASSERT_NEXT(a_done_sticky, clock, reset,
      advance && !is_term && phase_ff == PH_DONE, phase_ff == PH_DONE,
      "done phase left without a terminator")

   // A terminator taken into the result register always shows up as valid and clears the parse state.
   `STIP_ASSERT_NEXT(a_term_emits, clock, reset, out_load,
      out_valid_ff && pos_ff == '0 && phase_ff == PH_SPACE,
      "terminator did not produce a result or clear the parse state")

endmodule

// File: sim/string_to_integer_parser_tb.sv
// Self-checking testbench for the streaming string-to-integer parser.
// Depends on stip_pkg and string_to_integer_parser; predicts each conversion
// in a local model and compares every result item field by field.
module string_to_integer_parser_tb;
   import stip_pkg::*;

   localparam int                 CYCLE_LIMIT       = 600000;
   localparam int                 RANDOM_PER_SETTING = 70;
   localparam int                 OFFSET_TOP        = 65535;
   localparam logic [RADIX_W-1:0] RADIX_TOP         = 6'd63;

   typedef struct {
      logic [VALUE_W-1:0]  value;
      logic [END_W-1:0]    end_offset;
      logic [STATUS_W-1:0] status;
   } conversion_type;

   // Block ports.
   logic                   clock       = 1'b0;
   logic                   reset       = 1'b1;
   logic [CHAR_W-1:0]      req_tdata   = '0;
   logic                   req_tvalid  = 1'b0;
   logic                   req_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tvalid;
   logic                   rsp_tready  = 1'b0;
   logic                   csr_wr_en   = 1'b0;
   logic [RADIX_W-1:0]     csr_wr_data = '0;

   // Stimulus and bookkeeping.
   logic [CHAR_W-1:0] pending_chars[$];
   conversion_type    conversions_due[$];
   int unsigned       chars_queued    = 0;
   int unsigned       chars_accepted  = 0;
   int unsigned       strings_checked = 0;
   int unsigned       settings_run    = 0;
   int unsigned       mismatch_count  = 0;
   int unsigned       cycle_count     = 0;
   bit                req_fired       = 1'b0;
   int unsigned       burst_left      = 0;
   int unsigned       idle_left       = 0;
   int unsigned       gap_max         = 0;
   int unsigned       stall_left      = 0;
   int unsigned       stall_max       = 0;

   // Local copy of the parser state and the radix register.
   logic [RADIX_W-1:0] radix_reg;
   logic [PHASE_W-1:0] parse_phase;
   logic [VALUE_W-1:0] magnitude;
   bit                 negative;
   logic [RADIX_W-1:0] base_now;
   bit                 saturated;
   bit                 have_digits;
   int unsigned        char_pos;
   int unsigned        num_end;
   int unsigned        zero_end;

   string_to_integer_parser dut (
      .clock       (clock),
      .reset       (reset),
      .req_tdata   (req_tdata),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Digit value 0..35 of a character, or -1 when it is not alphanumeric.
   function automatic int digit_of(input logic [CHAR_W-1:0] c);
      if (c >= CH_0 && c <= CH_9) return int'(c - CH_0);
      if (c >= CH_LA && c <= CH_LZ) return int'(c - CH_LA) + int'(BASE_DEC);
      if (c >= CH_UA && c <= CH_UZ) return int'(c - CH_UA) + int'(BASE_DEC);
      return -1;
   endfunction

   function automatic void clear_parse_state();
      parse_phase = PH_SPACE;
      magnitude   = '0;
      negative    = 1'b0;
      base_now    = BASE_AUTO;
      saturated   = 1'b0;
      have_digits = 1'b0;
      char_pos    = 0;
      num_end     = 0;
      zero_end    = 0;
   endfunction

   // Accumulate one digit of the current base, or close the number.
   function automatic void accept_digit(input logic [CHAR_W-1:0] c, input int unsigned next_pos);
      int                 d;
      logic [VALUE_W-1:0] lim;
      logic [VALUE_W-1:0] ud;
      d = digit_of(c);
      if (d < 0 || d >= int'(base_now) || base_now < BASE_MIN) begin
         parse_phase = PH_DONE;
         return;
      end
      parse_phase = PH_DIGITS;
      have_digits = 1'b1;
      num_end     = next_pos;
      if (saturated) return;
      // The negative side may reach the exact signed minimum.
      lim = {1'b1, {(VALUE_W-1){1'b0}}} - (negative ? 64'd0 : 64'd1);
      ud  = 64'(d);
      if (magnitude > (lim - ud) / 64'(base_now)) begin
         saturated = 1'b1;
         magnitude = lim;
      end else begin
         magnitude = magnitude * 64'(base_now) + ud;
      end
   endfunction

   // First character after white space and sign; a zero may open a prefix.
   function automatic void begin_number(input logic [CHAR_W-1:0] c, input int unsigned next_pos);
      if (c == CH_0 && (base_now == BASE_AUTO || base_now == BASE_HEX)) begin
         have_digits = 1'b1;
         num_end     = next_pos;
         zero_end    = next_pos;
         parse_phase = PH_ZERO;
      end else begin
         if (base_now == BASE_AUTO) base_now = BASE_DEC;
         accept_digit(c, next_pos);
      end
   endfunction

   // Advance the local parser by one accepted character; a terminator
   // queues the conversion it completes.
   function automatic void parse_char(input logic [CHAR_W-1:0] c);
      conversion_type r;
      int unsigned    next_pos;
      int             d;
      // The radix is latched on the first character of each string.
      if (parse_phase == PH_SPACE && char_pos == 0) begin
         base_now = radix_reg;
         if (base_now == BASE_ONE || base_now > BASE_MAX) parse_phase = PH_INVALID;
      end
      if (c == CH_NUL) begin
         r.value      = '0;
         r.end_offset = '0;
         if (parse_phase == PH_INVALID) begin
            r.status = ST_BAD_BASE;
         end else if (!have_digits) begin
            r.status = ST_NO_DIGITS;
         end else begin
            r.value      = negative ? 64'd0 - magnitude : magnitude;
            r.end_offset = END_W'(num_end);
            r.status     = saturated ? ST_RANGE : ST_OK;
         end
         conversions_due.push_back(r);
         clear_parse_state();
         return;
      end
      next_pos = (char_pos < OFFSET_TOP) ? char_pos + 1 : char_pos;
      case (parse_phase)
         PH_SPACE: begin
            if (c == CH_MINUS) begin
               negative    = 1'b1;
               parse_phase = PH_SIGNED;
            end else if (c == CH_PLUS) begin
               parse_phase = PH_SIGNED;
            end else if (!(c == CH_SPACE || (c >= CH_TAB && c <= CH_CR))) begin
               begin_number(c, next_pos);
            end
         end
         PH_SIGNED: begin_number(c, next_pos);
         PH_ZERO: begin
            if (c == CH_LX || c == CH_UX) begin
               parse_phase = PH_XSEEN;
            end else begin
               if (base_now == BASE_AUTO) base_now = (c >= CH_0 && c <= CH_7) ? BASE_OCT : BASE_DEC;
               accept_digit(c, next_pos);
            end
         end
         PH_XSEEN: begin
            d = digit_of(c);
            if (d >= 0 && d < int'(BASE_HEX)) begin
               base_now = BASE_HEX;
               accept_digit(c, next_pos);
            end else begin
               // Only the zero before the x counts as converted.
               if (base_now == BASE_AUTO) base_now = BASE_DEC;
               num_end     = zero_end;
               parse_phase = PH_DONE;
            end
         end
         PH_DIGITS: accept_digit(c, next_pos);
         default: ;
      endcase
      char_pos = next_pos;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      mismatch_count++;
      $display("ERROR: %s is %0h, expected %0h (string %0d, cycle %0d)",
               what, got, want, strings_checked, cycle_count);
   endtask

   // Monitor: register writes, accepted characters and result items.
   always @(posedge clock) begin
      conversion_type      want;
      logic [VALUE_W-1:0]  got_value;
      logic [END_W-1:0]    got_end;
      logic [STATUS_W-1:0] got_status;
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("ERROR: run stopped at the cycle limit");
         $display("Mismatches found");
         $finish;
      end
      if (reset) begin
         radix_reg = RADIX_RESET;
         clear_parse_state();
      end else begin
         if (csr_wr_en) radix_reg = csr_wr_data;
         if (req_tvalid && req_tready) begin
            parse_char(req_tdata);
            chars_accepted++;
            req_fired = 1'b1;
         end
         if (rsp_tvalid && rsp_tready) begin
            got_value  = rsp_tdata[VALUE_W-1:0];
            got_end    = rsp_tdata[VALUE_W +: END_W];
            got_status = rsp_tdata[VALUE_W+END_W +: STATUS_W];
            if (conversions_due.size() == 0) begin
               report_mismatch("unrequested result value", got_value, '0);
            end else begin
               want = conversions_due.pop_front();
               if (got_value != want.value) report_mismatch("value", got_value, want.value);
               if (got_end != want.end_offset)
                  report_mismatch("end_offset", 64'(got_end), 64'(want.end_offset));
               if (got_status != want.status)
                  report_mismatch("status", 64'(got_status), 64'(want.status));
               strings_checked++;
            end
         end
      end
   end

   // Character driver: bursts of random length separated by random gaps.
   always @(negedge clock) begin
      if (!reset && (!req_tvalid || req_fired)) begin
         if (idle_left != 0) begin
            idle_left--;
            req_tvalid <= 1'b0;
         end else if (pending_chars.size() != 0) begin
            req_tdata  <= pending_chars.pop_front();
            req_tvalid <= 1'b1;
            if (burst_left <= 1) begin
               burst_left = $urandom_range(1, 32);
               idle_left  = $urandom_range(0, gap_max);
            end else begin
               burst_left--;
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
      req_fired = 1'b0;
   end

   // Result receiver: stalls of random length started at random.
   always @(negedge clock) begin
      if (stall_left != 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (stall_max != 0 && $urandom_range(0, 3) == 0) begin
         stall_left = $urandom_range(0, stall_max);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic push_char(input logic [CHAR_W-1:0] c);
      pending_chars.push_back(c);
      chars_queued++;
   endtask

   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++) push_char(s[i]);
      push_char(CH_NUL);
   endtask

   task automatic push_blank();
      int w;
      w = $urandom_range(0, 5);
      push_char(w == 5 ? CH_SPACE : CH_TAB + CHAR_W'(w));
   endtask

   task automatic push_digit(input int v);
      if (v < int'(BASE_DEC)) push_char(CH_0 + CHAR_W'(v));
      else if ($urandom_range(0, 1) != 0) push_char(CH_LA + CHAR_W'(v - int'(BASE_DEC)));
      else push_char(CH_UA + CHAR_W'(v - int'(BASE_DEC)));
   endtask

   task automatic push_hex_prefix();
      push_char(CH_0);
      push_char($urandom_range(0, 1) != 0 ? CH_LX : CH_UX);
   endtask

   // One random string: mostly well-formed numbers, some noise, some broken.
   task automatic queue_random_string(input logic [RADIX_W-1:0] r);
      int kind;
      int b;
      int n;
      kind = $urandom_range(0, 9);
      repeat ($urandom_range(0, 3)) push_blank();
      if (kind < 7) begin
         case ($urandom_range(0, 2))
            0: push_char(CH_MINUS);
            1: push_char(CH_PLUS);
            default: ;
         endcase
         b = int'(r);
         if (r == BASE_AUTO) begin
            case ($urandom_range(0, 2))
               0: begin
                  b = int'(BASE_OCT);
                  push_char(CH_0);
               end
               1: begin
                  b = int'(BASE_HEX);
                  push_hex_prefix();
               end
               default: b = int'(BASE_DEC);
            endcase
         end else if (r == BASE_HEX && $urandom_range(0, 2) == 0) begin
            push_hex_prefix();
         end else if (r == BASE_ONE || r > BASE_MAX) begin
            b = int'(BASE_DEC);
         end
         n = ($urandom_range(0, 4) == 0) ? $urandom_range(14, 24) : $urandom_range(1, 8);
         repeat (n) push_digit($urandom_range(0, b - 1));
         if ($urandom_range(0, 2) == 0)
            repeat ($urandom_range(1, 3)) push_char(CHAR_W'($urandom_range(1, 255)));
      end else if (kind < 9) begin
         repeat ($urandom_range(0, 8)) push_char(CHAR_W'($urandom_range(1, 255)));
      end else begin
         // Sign and prefix pieces that lead to no number or a cut-off one.
         push_char($urandom_range(0, 1) != 0 ? CH_MINUS : CH_PLUS);
         case ($urandom_range(0, 2))
            0: begin
               push_hex_prefix();
               push_char(CH_LA + CHAR_W'($urandom_range(6, 25)));
            end
            1: push_char(CH_PLUS);
            default: push_char(CHAR_W'($urandom_range(128, 255)));
         endcase
         repeat ($urandom_range(0, 3)) push_digit($urandom_range(0, 9));
      end
      push_char(CH_NUL);
   endtask

   // Hand-picked strings for each radix setting.
   task automatic queue_directed(input logic [RADIX_W-1:0] r);
      case (r)
         BASE_DEC: begin
            push_text("");
            push_text("\t\n\v\f\015 -42x");
            push_text("+9223372036854775807");
            push_text("-9223372036854775808");
            push_text("9223372036854775808");
            push_text("-+5");
            push_text("abc");
         end
         BASE_AUTO: begin
            push_text("0x1fZ");
            push_text("0Xg");
            push_text("017");
            push_text("08");
            push_text("-0x8000000000000000");
            push_text("0x");
         end
         BASE_HEX: begin
            push_text("0XfF");
            push_text("0xq");
            push_text("FFFFFFFFFFFFFFFFF");
         end
         BASE_MIN: begin
            push_text("-101");
            push_text("2");
            // Sixty-five ones run past the largest positive value.
            repeat (65) push_char(CH_0 + 8'd1);
            push_char(CH_NUL);
         end
         BASE_MAX: begin
            push_text("zZ9");
            push_text("-zzzzzzzzzzzzzz");
         end
         BASE_OCT: push_text("0x7");
         BASE_ONE: push_text("12");
         default: push_text("9");
      endcase
   endtask

   task automatic write_radix(input logic [RADIX_W-1:0] r);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= r;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // Wait until every queued character is taken and every result is back,
   // then let the pipeline settle.
   task automatic wait_idle();
      while (chars_accepted != chars_queued || conversions_due.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic run_setting(input logic [RADIX_W-1:0] r, input bit do_write);
      int unsigned start;
      if (do_write) write_radix(r);
      // Idling differs per setting, including stretches with none at all.
      case (settings_run % 3)
         0: begin
            gap_max   = 0;
            stall_max = 0;
         end
         1: begin
            gap_max   = 3;
            stall_max = 4;
         end
         default: begin
            gap_max   = 10;
            stall_max = 20;
         end
      endcase
      queue_directed(r);
      start = chars_queued;
      while (chars_queued - start < RANDOM_PER_SETTING) queue_random_string(r);
      wait_idle();
      settings_run++;
   endtask

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      run_setting(BASE_DEC, 1'b0);
      run_setting(BASE_AUTO, 1'b1);
      run_setting(BASE_HEX, 1'b1);
      run_setting(BASE_MIN, 1'b1);
      run_setting(BASE_MAX, 1'b1);
      run_setting(BASE_OCT, 1'b1);
      run_setting(BASE_ONE, 1'b1);
      run_setting(RADIX_TOP, 1'b1);
      run_setting(RADIX_W'($urandom_range(3, 35)), 1'b1);

      repeat (8) @(negedge clock);
      $display("Run covered %0d strings (%0d characters) over %0d radix settings.",
               strings_checked, chars_accepted, settings_run);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

// File: string_to_integer_parser.f
+incdir+design
design/stip_pkg.sv
design/string_to_integer_parser.sv
sim/string_to_integer_parser_tb.sv
